FILE: src/chm_pkg.sv
// Shared types, constants and status codes for the calorimeter hit merger.
// No dependencies; every other file of the block imports this package.
package chm_pkg;

	localparam int NUM_CELLS_DEF     = 1024;
	localparam int HITS_PER_CELL_DEF = 32;

	localparam int TW  = 20;
	localparam int EW  = 24;
	localparam int ZW  = 12;
	localparam int IDW = 7;
	localparam int NUM_REGS = 3;

	localparam logic [1:0] REG_THRESH = 2'd0;
	localparam logic [1:0] REG_RES    = 2'd1;
	localparam logic [1:0] REG_LIMIT  = 2'd2;

	localparam logic [EW-1:0] E_MAX = {EW{1'b1}};

	typedef enum logic [2:0] {
		ST_MERGED   = 3'd0,
		ST_NEW      = 3'd1,
		ST_DROPPED  = 3'd2,
		ST_RO_HIT   = 3'd3,
		ST_RO_EMPTY = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_CNT,
		S_RD,
		S_CHK,
		S_MUL_T,
		S_MUL_T2,
		S_MUL_Z,
		S_MUL_Z2,
		S_DIV,
		S_WB,
		S_APPEND,
		S_RO_RD,
		S_RO_CHK,
		S_DONE
	} state_t;

	// Start request and answer of the shared divider
	typedef struct packed {
		logic               start;
		logic               neg;
		logic [EW+TW:0]     num;
		logic [EW:0]        den;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [EW+TW:0]     quo;
	} div_rsp_t;

endpackage

FILE: src/chm_div.sv
// Restoring divider, one quotient bit per cycle, with floor rounding for
// negative numerators. Depends on chm_pkg.
module chm_div
	import chm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int NW = EW + TW + 1;
	localparam int DW = EW + 1;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] quo_q;
	logic [DW:0]   rem_q;
	logic [DW-1:0] den_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic [DW:0]   shifted;

	// Shift in the next numerator bit and try the subtract
	assign shifted = {rem_q[DW-1:0], quo_q[NW-1]};
	assign trial   = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			den_q <= req.den;
			neg_q <= req.neg;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[DW]) begin
				rem_q <= trial;
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	// Floor: a negative quotient with a remainder steps down one more
	always_comb begin
		rsp.done = done_q;
		if (neg_q)
			rsp.quo = (rem_q != '0) ? ~quo_q : (~quo_q + 1'b1);
		else
			rsp.quo = quo_q;
	end

endmodule

FILE: src/calorimeter_hit_merger_top.sv
// Top level of the calorimeter hit merger: sequencer, hit memories, one
// shared multiplier and the shared divider. Depends on chm_pkg, chm_div.
//
// After reset the block clears the per-cell hit counts, one cell per cycle,
// and holds busy high until all NUM_CELLS cells (1024 by default) are
// cleared. A word is taken when start is high and busy is low; busy then
// stays high until the last result has gone out. A zero-energy deposit
// gives no result; a deposit that does not merge walks every stored hit of
// the cell, each one costing a registered memory read and a compare; a
// deposit that merges with hit k (counting from one) walks hits one to k,
// then runs four multiplier steps and two divider passes; a readout walks
// every stored hit of the cell. Each result is on the outputs for one cycle,
// marked by done; the receiver cannot stall them.
module calorimeter_hit_merger_top
	import chm_pkg::*;
#(
	parameter int NUM_CELLS     = NUM_CELLS_DEF,
	parameter int HITS_PER_CELL = HITS_PER_CELL_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic                   mode,
	input  logic [9:0]             cell_req,
	input  logic [TW-1:0]          hit_time,
	input  logic [EW-1:0]          energy,
	input  logic signed [ZW-1:0]   z_local,
	input  logic [IDW-1:0]         incident,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [1:0]             cfg_index,
	input  logic [EW-1:0]          cfg_data,
	output logic                   done,
	output logic [2:0]             status,
	output logic [TW-1:0]          out_time,
	output logic [EW-1:0]          out_energy,
	output logic signed [ZW-1:0]   out_z,
	output logic [IDW-1:0]         out_incident,
	output logic                   last
);

	localparam int CIW  = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
	localparam int HIW  = (HITS_PER_CELL > 1) ? $clog2(HITS_PER_CELL) : 1;
	localparam int HCW  = $clog2(HITS_PER_CELL + 1);
	localparam int ADW  = CIW + HIW;
	localparam int DEP  = NUM_CELLS * (2 ** HIW);
	localparam int PW   = EW + TW + 1;
	localparam int MW   = TW + EW + 2;

	// Configuration registers
	logic [EW-1:0] thresh_q;
	logic [TW-1:0] res_q;
	logic [5:0]    limit_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= EW'(1000);
			res_q    <= TW'(800);
			limit_q  <= 6'd32;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_THRESH: thresh_q <= cfg_data;
				REG_RES:    res_q    <= cfg_data[TW-1:0];
				REG_LIMIT:  limit_q  <= cfg_data[5:0];
				default:    ;
			endcase
		end
	end

	// Memories: per-cell count and hit fields
	logic [HCW-1:0] cnt_mem [NUM_CELLS];
	logic [TW-1:0]  t_mem [DEP];
	logic [EW-1:0]  e_mem [DEP];
	logic [ZW-1:0]  z_mem [DEP];
	logic [IDW-1:0] id_mem [DEP];

	state_t state_q, state_d;

	logic           mode_q;
	logic [CIW-1:0] cell_q;
	logic           cell_ok_q;
	logic [TW-1:0]  t_q;
	logic [EW-1:0]  e_q;
	logic [ZW-1:0]  z_q;
	logic [IDW-1:0] id_q;
	logic [HCW-1:0] cnt_q;
	logic [HCW-1:0] idx_q;
	logic           found_q;
	logic [CIW-1:0] clr_q;

	logic [HCW-1:0] cnt_rd_q;
	logic [TW-1:0]  rt_q;
	logic [EW-1:0]  re_q;
	logic [ZW-1:0]  rz_q;
	logic [IDW-1:0] rid_q;

	logic [TW-1:0]  ho_t_q;
	logic [EW-1:0]  ho_e_q;
	logic [ZW-1:0]  ho_z_q;
	logic [IDW-1:0] ho_id_q;

	logic [PW-1:0]  prod_q;
	logic [PW-1:0]  tsum_q;
	logic [PW-1:0]  zsum_q;
	logic [TW-1:0]  tnew_q;
	logic           div_pass_q;

	logic           cnt_we;
	logic [HCW-1:0] cnt_wd;
	logic [CIW-1:0] cnt_wa;
	logic [CIW-1:0] cnt_ra;
	logic           hit_we;
	logic [ADW-1:0] hit_wa;
	logic [ADW-1:0] rd_addr;

	logic signed [TW:0]   mul_a;
	logic signed [EW:0]   mul_b;
	logic signed [MW-1:0] mul_p;

	div_req_t dreq;
	div_rsp_t drsp;

	chm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	logic [HCW-1:0] limit_eff;
	logic [TW-1:0]  tdiff;
	logic           hit_match;
	logic [EW:0]    esum;
	logic           scan_end;

	assign limit_eff = ({26'd0, limit_q} > 32'(HITS_PER_CELL)) ? HCW'(HITS_PER_CELL)
	                                                            : HCW'(limit_q);
	assign tdiff     = (rt_q > t_q) ? rt_q - t_q : t_q - rt_q;
	assign hit_match = tdiff < res_q;
	assign esum      = {1'b0, re_q} + {1'b0, e_q};
	assign scan_end  = (idx_q + 1'b1) >= cnt_q;
	assign rd_addr   = {cell_q, idx_q[HIW-1:0]};
	assign cnt_ra    = (state_q == S_IDLE) ? CIW'(cell_req) : cell_q;
	assign busy      = state_q != S_IDLE;

	// Shared multiplier: pick the operand pair of the current step
	always_comb begin
		unique case (state_q)
			S_MUL_T:  mul_a = {1'b0, rt_q};
			S_MUL_T2: mul_a = {1'b0, t_q};
			S_MUL_Z:  mul_a = (TW+1)'($signed(rz_q));
			S_MUL_Z2: mul_a = (TW+1)'($signed(z_q));
			default:  mul_a = '0;
		endcase
	end

	assign mul_b = (state_q == S_MUL_T || state_q == S_MUL_Z) ? {1'b0, re_q} : {1'b0, e_q};
	assign mul_p = mul_a * mul_b;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR:  if (clr_q == CIW'(NUM_CELLS - 1)) state_d = S_IDLE;
			S_IDLE:   if (start) state_d = S_CNT;
			S_CNT: begin
				priority if (!mode_q && e_q == '0) state_d = S_IDLE;
				else if (!cell_ok_q)               state_d = S_DONE;
				else if (cnt_rd_q == '0)           state_d = mode_q ? S_DONE : S_APPEND;
				else                               state_d = mode_q ? S_RO_RD : S_RD;
			end
			S_RD:     state_d = S_CHK;
			S_CHK: begin
				priority if (hit_match) state_d = S_MUL_T;
				else if (scan_end)      state_d = S_APPEND;
				else                    state_d = S_RD;
			end
			S_MUL_T:  state_d = S_MUL_T2;
			S_MUL_T2: state_d = S_MUL_Z;
			S_MUL_Z:  state_d = S_MUL_Z2;
			S_MUL_Z2: state_d = S_DIV;
			S_DIV:    if (drsp.done && div_pass_q) state_d = S_WB;
			S_WB:     state_d = S_IDLE;
			S_APPEND: state_d = S_IDLE;
			S_RO_RD:  state_d = S_RO_CHK;
			S_RO_CHK: state_d = scan_end ? S_DONE : S_RO_RD;
			S_DONE:   state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// Outputs of the sequencer; a readout hit above the threshold is held back
	// until the next such hit is found, so the final one can carry last
	always_comb begin
		done = 1'b0;
		status = ST_MERGED;
		out_time = '0;
		out_energy = '0;
		out_z = '0;
		out_incident = '0;
		last = 1'b0;
		cnt_we = 1'b0;
		cnt_wd = '0;
		cnt_wa = cell_q;
		hit_we = 1'b0;
		hit_wa = rd_addr;
		dreq = '0;
		unique case (state_q)
			S_CLEAR: begin
				cnt_we = 1'b1; cnt_wa = clr_q;
			end
			S_CNT: if (mode_q && cell_ok_q) cnt_we = 1'b1;
			S_WB: begin
				done = 1'b1; last = 1'b1; status = ST_MERGED; hit_we = 1'b1;
			end
			S_APPEND: begin
				done = 1'b1; last = 1'b1;
				if (cnt_q < limit_eff) begin
					status = ST_NEW; hit_we = 1'b1;
					hit_wa = {cell_q, cnt_q[HIW-1:0]};
					cnt_we = 1'b1; cnt_wd = cnt_q + 1'b1;
				end else begin
					status = ST_DROPPED;
				end
			end
			S_RO_CHK: if (re_q > thresh_q && found_q) begin
				done = 1'b1; status = ST_RO_HIT;
				out_time = ho_t_q; out_energy = ho_e_q; out_z = ho_z_q;
				out_incident = ho_id_q;
			end
			S_DONE: begin
				done = 1'b1; last = 1'b1;
				if (mode_q && found_q) begin
					status = ST_RO_HIT;
					out_time = ho_t_q; out_energy = ho_e_q; out_z = ho_z_q;
					out_incident = ho_id_q;
				end else begin
					status = mode_q ? ST_RO_EMPTY : ST_DROPPED;
				end
			end
			S_MUL_Z2: begin
				dreq.start = 1'b1;
				dreq.neg   = 1'b0;
				dreq.num   = tsum_q;
				dreq.den   = esum;
			end
			S_DIV: if (drsp.done && !div_pass_q) begin
				dreq.start = 1'b1;
				dreq.neg   = zsum_q[PW-1];
				dreq.num   = zsum_q[PW-1] ? ~zsum_q + 1'b1 : zsum_q;
				dreq.den   = esum;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			found_q <= 1'b0;
			div_pass_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == S_IDLE) found_q <= 1'b0;
			if (state_q == S_RO_CHK && re_q > thresh_q) found_q <= 1'b1;
			if (state_q == S_MUL_Z2) div_pass_q <= 1'b0;
			if (state_q == S_DIV && drsp.done) div_pass_q <= 1'b1;
		end
	end

	// Capture the word, walk the list, run the shared multiplier, write the memories
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			mode_q    <= mode;
			cell_ok_q <= 32'(cell_req) < NUM_CELLS;
			cell_q    <= CIW'(cell_req);
			t_q <= hit_time; e_q <= energy; z_q <= z_local; id_q <= incident;
			idx_q <= '0;
		end
		if (state_q == S_CNT) cnt_q <= cnt_rd_q;
		if ((state_q == S_CHK && !hit_match) || state_q == S_RO_CHK)
			idx_q <= idx_q + 1'b1;
		if (state_q == S_MUL_T) prod_q <= mul_p[PW-1:0];
		if (state_q == S_MUL_T2) tsum_q <= prod_q + mul_p[PW-1:0];
		if (state_q == S_MUL_Z) prod_q <= mul_p[PW-1:0];
		if (state_q == S_MUL_Z2) zsum_q <= prod_q + mul_p[PW-1:0];
		if (state_q == S_DIV && drsp.done && !div_pass_q) tnew_q <= drsp.quo[TW-1:0];
		if (state_q == S_RO_CHK && re_q > thresh_q) begin
			ho_t_q <= rt_q; ho_e_q <= re_q; ho_z_q <= rz_q; ho_id_q <= rid_q;
		end
		cnt_rd_q <= cnt_mem[cnt_ra];
		if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
		if (state_q == S_RD || state_q == S_RO_RD) begin
			rt_q  <= t_mem[rd_addr];
			re_q  <= e_mem[rd_addr];
			rz_q  <= z_mem[rd_addr];
			rid_q <= id_mem[rd_addr];
		end
		if (hit_we) begin
			if (state_q == S_WB) begin
				t_mem[hit_wa] <= tnew_q;
				z_mem[hit_wa] <= drsp.quo[ZW-1:0];
				e_mem[hit_wa] <= esum[EW] ? E_MAX : esum[EW-1:0];
			end else begin
				t_mem[hit_wa]  <= t_q;
				e_mem[hit_wa]  <= e_q;
				z_mem[hit_wa]  <= z_q;
				id_mem[hit_wa] <= id_q;
			end
		end
	end

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("start not taken");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result outside an item");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(done && last) |=> !busy) else $error("item runs on after last");
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(hit_we && state_q == S_RO_CHK)) else $error("write during readout");

endmodule
